// ===== rtl/osnl_pkg.sv =====
// Shared types and constants of the option string number lookup unit.
// No dependencies; every file but osnl_channels takes names from here by scope.
package osnl_pkg;

    localparam int KEY_IDX_W   = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int QUEUE_DEPTH = 2;   // power of two
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_TEXT       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_NUMBER = 2'd2;

    // outcome codes
    localparam logic [1:0] OUT_ABSENT  = 2'd0;
    localparam logic [1:0] OUT_DEC     = 2'd1;
    localparam logic [1:0] OUT_HEX     = 2'd2;
    localparam logic [1:0] OUT_BAD_HEX = 2'd3;

    // one classified character as it travels from front to back
    typedef struct packed {
        logic [7:0] ch;
        logic       is_zero;
        logic       is_comma;
        logic       is_equal;
        logic       is_space;
        logic       is_ws;
        logic       is_digit;
        logic       is_hex;
        logic       is_x;
        logic       is_plus;
        logic       is_minus;
        logic [3:0] nibble;
    } byte_class_t;

endpackage

// ===== rtl/osnl_channels.sv =====
// Valid/ready channel interfaces for the character input and the result output.
// No dependencies.
interface osnl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface osnl_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] number;
    logic [1:0]         outcome;

    modport source (output valid, output number, output outcome, input ready);
    modport sink   (input valid, input number, input outcome, output ready);
endinterface

// ===== rtl/osnl_front.sv =====
// Front end: accepts characters and classifies them into one registered request.
// Depends on osnl_pkg and osnl_channels.
module osnl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    osnl_in_if.sink              text,
    output logic                 item_valid,
    input  logic                 item_ready,
    output osnl_pkg::byte_class_t item
);

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    osnl_pkg::byte_class_t cls;
    osnl_pkg::byte_class_t item_reg;
    logic                  valid_reg;
    logic [7:0]            c;
    logic                  upper;
    logic                  lower;

    assign c     = text.text_byte;
    assign upper = (c >= CH_UA) && (c <= CH_UF);
    assign lower = (c >= CH_LA) && (c <= CH_LF);

    always_comb
    begin
        cls          = '0;
        cls.ch       = c;
        cls.is_zero  = (c == 8'h00);
        cls.is_comma = (c == CH_COMMA);
        cls.is_equal = (c == CH_EQUAL);
        cls.is_space = (c == CH_SPACE);
        cls.is_ws    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        cls.is_digit = (c >= CH_0) && (c <= CH_9);
        cls.is_hex   = cls.is_digit || upper || lower;
        cls.is_x     = (c == CH_X);
        cls.is_plus  = (c == CH_PLUS);
        cls.is_minus = (c == CH_MINUS);
        // letters map to 10..15, digits to 0..9
        if (upper || lower)
        begin
            cls.nibble = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        else
        begin
            cls.nibble = c[3:0];
        end
    end

    assign text.ready = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (text.valid && text.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            item_reg <= cls;
        end
    end

endmodule

// ===== rtl/osnl_queue.sv =====
// Short request queue between the front end and the back end.
// Depends on osnl_pkg.
module osnl_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  osnl_pkg::byte_class_t push_item,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output osnl_pkg::byte_class_t pop_item
);

    osnl_pkg::byte_class_t                entry_mem [osnl_pkg::QUEUE_DEPTH];
    logic [osnl_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [osnl_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [osnl_pkg::QUEUE_CNT_W-1:0]     count_reg;
    logic                                 push;
    logic                                 pop;

    assign push_ready = (count_reg != osnl_pkg::QUEUE_CNT_W'(osnl_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/osnl_back.sv =====
// Back end: walks the entry/name/value state per request and registers the result.
// Depends on osnl_pkg and osnl_channels.
module osnl_back #(
    parameter int KEY_CHARS   = 8,
    parameter int VALUE_CHARS = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  osnl_pkg::byte_class_t item,
    input  logic [63:0]           key_text,
    input  logic [3:0]            key_length,
    input  logic [31:0]           default_number,
    osnl_out_if.source            result
);

    localparam int VCW = $clog2(VALUE_CHARS + 1);
    localparam logic [VCW-1:0] VMAX = VCW'(VALUE_CHARS);
    localparam logic [osnl_pkg::KEY_IDX_W-1:0] KEY_MAX = osnl_pkg::KEY_IDX_W'(KEY_CHARS);

    typedef enum logic [2:0] {
        PH_START, PH_SPACES, PH_NAME, PH_SKIP, PH_VLEAD, PH_VZERO, PH_HEX, PH_DEC
    } phase_t;

    typedef enum logic [1:0] {
        MD_UNDEC, MD_DIGITS, MD_STOPPED, MD_BAD
    } mode_t;

    phase_t                          phase_reg, phase_next;
    logic [osnl_pkg::KEY_IDX_W-1:0]  key_index_reg, key_index_next;
    logic                            still_eq_reg, still_eq_next;
    logic [VCW-1:0]                  vcnt_reg, vcnt_next;
    logic [31:0]                     acc_reg, acc_next;
    mode_t                           mode_reg, mode_next;
    logic                            neg_reg, neg_next;
    logic                            found_reg, found_next;
    logic                            out_valid_reg;
    logic [31:0]                     number_reg, number_next;
    logic [1:0]                      outcome_reg, outcome_next;

    logic [osnl_pkg::KEY_IDX_W-1:0]  eff_len;
    logic                            name_match;
    logic [7:0]                      key_byte;
    logic                            out_free;
    logic                            pop;
    logic                            in_value;
    logic [31:0]                     acc_x10;

    assign eff_len    = (key_length > KEY_MAX) ? KEY_MAX : key_length;
    assign name_match = still_eq_reg && (key_index_reg == eff_len);
    assign key_byte   = key_text[{key_index_reg[2:0], 3'b000} +: 8];
    assign out_free   = !out_valid_reg || result.ready;
    assign item_ready = !item.is_zero || out_free;
    assign pop        = item_valid && item_ready;
    assign in_value   = (phase_reg == PH_VLEAD) || (phase_reg == PH_VZERO) ||
                        (phase_reg == PH_HEX) || (phase_reg == PH_DEC);

    assign result.valid   = out_valid_reg;
    assign result.number  = $signed(number_reg);
    assign result.outcome = outcome_reg;

    always_comb
    begin
        logic        do_dec;
        mode_t       dk;
        logic        dn;
        logic [31:0] da;
        logic        bare;
        logic        f_e;
        phase_t      p_e;
        logic        n_e;
        logic [31:0] a_e;
        mode_t       m_e;

        phase_next     = phase_reg;
        key_index_next = key_index_reg;
        still_eq_next  = still_eq_reg;
        vcnt_next      = vcnt_reg;
        acc_next       = acc_reg;
        mode_next      = mode_reg;
        neg_next       = neg_reg;
        found_next     = found_reg;
        number_next    = number_reg;
        outcome_next   = outcome_reg;
        do_dec         = 1'b0;
        dk             = mode_reg;
        dn             = neg_reg;
        da             = acc_reg;
        bare           = 1'b0;
        f_e            = found_reg;
        p_e            = phase_reg;
        n_e            = neg_reg;
        a_e            = acc_reg;
        m_e            = mode_reg;

        if (item.is_zero)
        begin
            // a trailing bare name that matches counts as found with zero
            bare = ((phase_reg == PH_SPACES) || (phase_reg == PH_NAME)) && name_match;
            if (bare)
            begin
                f_e = 1'b1;
                p_e = PH_DEC;
                n_e = 1'b0;
                a_e = '0;
                m_e = MD_STOPPED;
            end
            if (!f_e)
            begin
                number_next  = default_number;
                outcome_next = osnl_pkg::OUT_ABSENT;
            end
            else if (p_e == PH_HEX)
            begin
                if (m_e == MD_BAD)
                begin
                    number_next  = default_number;
                    outcome_next = osnl_pkg::OUT_BAD_HEX;
                end
                else
                begin
                    number_next  = a_e;
                    outcome_next = osnl_pkg::OUT_HEX;
                end
            end
            else if (p_e == PH_DEC)
            begin
                number_next  = n_e ? (32'd0 - a_e) : a_e;
                outcome_next = osnl_pkg::OUT_DEC;
            end
            else
            begin
                number_next  = '0;
                outcome_next = osnl_pkg::OUT_DEC;
            end
            // clear for the next string
            phase_next     = PH_START;
            key_index_next = '0;
            still_eq_next  = 1'b1;
            vcnt_next      = '0;
            acc_next       = '0;
            mode_next      = MD_UNDEC;
            neg_next       = 1'b0;
            found_next     = 1'b0;
        end
        else if (in_value)
        begin
            if (vcnt_reg >= VMAX)
            begin
                // drop characters past the value limit
            end
            else if (item.is_comma)
            begin
                vcnt_next = VMAX;
            end
            else
            begin
                vcnt_next = vcnt_reg + 1'b1;
                case (phase_reg)
                    PH_VLEAD:
                    begin
                        if (item.ch == 8'h30)
                        begin
                            phase_next = PH_VZERO;
                        end
                        else if (!item.is_space)
                        begin
                            phase_next = PH_DEC;
                            do_dec     = 1'b1;
                            dk         = MD_UNDEC;
                            dn         = 1'b0;
                        end
                    end
                    PH_VZERO:
                    begin
                        if (item.is_x)
                        begin
                            phase_next = PH_HEX;
                            acc_next   = '0;
                            mode_next  = MD_UNDEC;
                            neg_next   = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_DEC;
                            do_dec     = 1'b1;
                            dk         = MD_DIGITS;
                            dn         = 1'b0;
                            da         = '0;
                        end
                    end
                    PH_HEX:
                    begin
                        if (mode_reg != MD_BAD)
                        begin
                            if (item.is_hex)
                            begin
                                acc_next = {acc_reg[27:0], item.nibble};
                            end
                            else
                            begin
                                mode_next = MD_BAD;
                            end
                        end
                    end
                    default:
                    begin
                        do_dec = 1'b1;
                    end
                endcase
            end
        end
        else if (phase_reg == PH_SKIP)
        begin
            if (item.is_comma)
            begin
                phase_next     = PH_START;
                key_index_next = '0;
                still_eq_next  = 1'b1;
            end
        end
        else if (((phase_reg == PH_START) || (phase_reg == PH_SPACES)) && item.is_space)
        begin
            phase_next = PH_SPACES;
        end
        else if (item.is_comma)
        begin
            if (name_match)
            begin
                found_next = 1'b1;
                phase_next = PH_DEC;
                mode_next  = MD_STOPPED;
                neg_next   = 1'b0;
                acc_next   = '0;
                vcnt_next  = VMAX;
            end
            else
            begin
                phase_next     = PH_START;
                key_index_next = '0;
                still_eq_next  = 1'b1;
            end
        end
        else if (item.is_equal)
        begin
            if (name_match)
            begin
                found_next = 1'b1;
                phase_next = PH_VLEAD;
                vcnt_next  = '0;
                acc_next   = '0;
                mode_next  = MD_UNDEC;
                neg_next   = 1'b0;
            end
            else
            begin
                phase_next = PH_SKIP;
            end
        end
        else
        begin
            if (still_eq_reg && (key_index_reg < eff_len) && (key_byte == item.ch))
            begin
                key_index_next = key_index_reg + 1'b1;
            end
            else
            begin
                still_eq_next = 1'b0;
            end
            phase_next = PH_NAME;
        end

        // atoi step: skip blanks, one sign, then digits until a non-digit
        acc_x10 = {da[28:0], 3'b000} + {da[30:0], 1'b0} + {28'd0, item.nibble};
        if (do_dec)
        begin
            mode_next = dk;
            neg_next  = dn;
            acc_next  = da;
            case (dk)
                MD_UNDEC:
                begin
                    if (item.is_ws)
                    begin
                        mode_next = MD_UNDEC;
                    end
                    else if (item.is_plus)
                    begin
                        mode_next = MD_DIGITS;
                        neg_next  = 1'b0;
                    end
                    else if (item.is_minus)
                    begin
                        mode_next = MD_DIGITS;
                        neg_next  = 1'b1;
                    end
                    else if (item.is_digit)
                    begin
                        acc_next  = {28'd0, item.nibble};
                        mode_next = MD_DIGITS;
                        neg_next  = 1'b0;
                    end
                    else
                    begin
                        mode_next = MD_STOPPED;
                        neg_next  = 1'b0;
                    end
                end
                MD_DIGITS:
                begin
                    if (item.is_digit)
                    begin
                        acc_next = acc_x10;
                    end
                    else
                    begin
                        mode_next = MD_STOPPED;
                    end
                end
                default:
                begin
                    mode_next = dk;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            key_index_reg <= '0;
            still_eq_reg  <= 1'b1;
            vcnt_reg      <= '0;
            acc_reg       <= '0;
            mode_reg      <= MD_UNDEC;
            neg_reg       <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg     <= phase_next;
                key_index_reg <= key_index_next;
                still_eq_reg  <= still_eq_next;
                vcnt_reg      <= vcnt_next;
                acc_reg       <= acc_next;
                mode_reg      <= mode_next;
                neg_reg       <= neg_next;
                found_reg     <= found_next;
            end
            if (pop && item.is_zero)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && item.is_zero)
        begin
            number_reg  <= number_next;
            outcome_reg <= outcome_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && item.is_zero) |=> (phase_reg == PH_START && !found_reg && vcnt_reg == '0))
        else $error("state not cleared after end of string");

    a_result_follows_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && item.is_zero) |=> out_valid_reg)
        else $error("no result after end of string");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && item.is_zero) |-> (!out_valid_reg || result.ready))
        else $error("result overwritten while stalled");

    a_value_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcnt_reg <= VMAX)
        else $error("value count past limit");

    a_value_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_VLEAD || phase_reg == PH_VZERO || phase_reg == PH_HEX ||
         phase_reg == PH_DEC) |-> found_reg)
        else $error("value phase without a matched key");
`endif

endmodule

// ===== rtl/option_string_number_lookup_unit.sv =====
// A zero byte passes the front register and the queue; the back end registers its result.
// Throughput: one character per cycle, unless a zero byte waits for a pending result.
// The front register, request queue and output register let either side stall alone.
// Reset clears all parse state, empties the queue, drops any pending result and
// zeroes the key, key length and default registers.
module option_string_number_lookup_unit #(
    parameter int KEY_CHARS   = 8,
    parameter int VALUE_CHARS = 31
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [osnl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [63:0]                        cfg_data,
    osnl_in_if.sink                            text,
    osnl_out_if.source                         result
);

    logic [63:0]           key_text_reg;
    logic [3:0]            key_length_reg;
    logic [31:0]           default_reg;

    logic                  f_valid;
    logic                  f_ready;
    osnl_pkg::byte_class_t f_item;
    logic                  q_valid;
    logic                  q_ready;
    osnl_pkg::byte_class_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_text_reg   <= '0;
            key_length_reg <= '0;
            default_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                osnl_pkg::REG_KEY_TEXT:       key_text_reg   <= cfg_data;
                osnl_pkg::REG_KEY_LENGTH:     key_length_reg <= cfg_data[3:0];
                osnl_pkg::REG_DEFAULT_NUMBER: default_reg    <= cfg_data[31:0];
                default:
                begin
                    key_text_reg <= key_text_reg;
                end
            endcase
        end
    end

    osnl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    osnl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    osnl_back #(
        .KEY_CHARS   (KEY_CHARS),
        .VALUE_CHARS (VALUE_CHARS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (q_valid),
        .item_ready     (q_ready),
        .item           (q_item),
        .key_text       (key_text_reg),
        .key_length     (key_length_reg),
        .default_number (default_reg),
        .result         (result)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for option_string_number_lookup_unit: random option strings
// over several key settings, checked against a scoreboard with its own parser.
// Depends on osnl_pkg and the osnl_in_if / osnl_out_if channel interfaces.
`timescale 1ns / 100ps

module tb_top;

    localparam int KEY_CHARS        = 8;
    localparam int VALUE_CHARS      = 31;
    localparam int ITEM_TARGET      = 1100;
    localparam int SETTINGS_COUNT   = 10;
    localparam int MODE_SPLIT       = 370;
    localparam int LONG_HOLD_AT     = 150;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT   = 4000;

    typedef enum logic [2:0] {
        ENTRY_START, ENTRY_SPACES, NAME_TEXT, SKIP_ENTRY,
        VALUE_LEAD, VALUE_ZERO, VALUE_HEX, VALUE_DEC
    } parse_step_t;

    typedef enum logic [1:0] {NUM_UNDECIDED, NUM_DIGITS, NUM_STOPPED, NUM_BAD} digit_state_t;

    typedef struct packed {
        bit [31:0] number;
        bit [1:0]  outcome;
    } lookup_answer_t;

    class lookup_scoreboard;
        bit [63:0]      key_text;
        bit [3:0]       key_len;
        bit [31:0]      default_value;
        parse_step_t    step;
        int unsigned    key_pos;
        bit             key_equal;
        int unsigned    value_count;
        bit [31:0]      acc;
        digit_state_t   digits;
        bit             negative;
        bit             found;
        lookup_answer_t expected_answers[$];
        int             failures;
        int             answers_seen;
        int             outcome_tally[4];

        function new();
            key_text = '0;
            key_len = '0;
            default_value = '0;
            failures = 0;
            answers_seen = 0;
            foreach (outcome_tally[i])
                outcome_tally[i] = 0;
            clear_string();
        endfunction

        function int unsigned pending();
            return expected_answers.size();
        endfunction

        function void start_entry();
            step = ENTRY_START;
            key_pos = 0;
            key_equal = 1'b1;
        endfunction

        function void clear_string();
            start_entry();
            value_count = 0;
            acc = '0;
            digits = NUM_UNDECIDED;
            negative = 1'b0;
            found = 1'b0;
        endfunction

        function int unsigned key_span();
            return (key_len > KEY_CHARS) ? KEY_CHARS : key_len;
        endfunction

        function bit name_hit();
            return key_equal && key_pos == key_span();
        endfunction

        // bare name: value 0, rest of the string ignored
        function void take_bare();
            found = 1'b1;
            step = VALUE_DEC;
            digits = NUM_STOPPED;
            negative = 1'b0;
            acc = '0;
            value_count = VALUE_CHARS;
        endfunction

        function void take_decimal(bit [7:0] c);
            bit is_digit;
            is_digit = c >= "0" && c <= "9";
            case (digits)
                NUM_UNDECIDED:
                begin
                    if (!(c == " " || (c >= 8'd9 && c <= 8'd13)))
                    begin
                        if (c == "+")
                        begin
                            digits = NUM_DIGITS;
                            negative = 1'b0;
                        end
                        else if (c == "-")
                        begin
                            digits = NUM_DIGITS;
                            negative = 1'b1;
                        end
                        else if (is_digit)
                        begin
                            acc = 32'(c - "0");
                            digits = NUM_DIGITS;
                        end
                        else
                        begin
                            digits = NUM_STOPPED;
                            negative = 1'b0;
                        end
                    end
                end
                NUM_DIGITS:
                begin
                    if (is_digit)
                        acc = acc * 32'd10 + 32'(c - "0");
                    else
                        digits = NUM_STOPPED;
                end
                default: ;
            endcase
        endfunction

        function void write_register(bit [osnl_pkg::CFG_INDEX_W-1:0] idx, bit [63:0] data);
            case (idx)
                osnl_pkg::REG_KEY_TEXT:       key_text = data;
                osnl_pkg::REG_KEY_LENGTH:     key_len = data[3:0];
                osnl_pkg::REG_DEFAULT_NUMBER: default_value = data[31:0];
                default: ;
            endcase
        endfunction

        function void note_request(bit [7:0] c);
            lookup_answer_t ans;
            if (c == 8'h00)
            begin
                if ((step == ENTRY_SPACES || step == NAME_TEXT) && name_hit())
                    take_bare();
                if (!found)
                begin
                    ans = '{default_value, osnl_pkg::OUT_ABSENT};
                end
                else if (step == VALUE_HEX)
                begin
                    if (digits == NUM_BAD)
                        ans = '{default_value, osnl_pkg::OUT_BAD_HEX};
                    else
                        ans = '{acc, osnl_pkg::OUT_HEX};
                end
                else if (step == VALUE_DEC)
                begin
                    ans = '{negative ? 32'd0 - acc : acc, osnl_pkg::OUT_DEC};
                end
                else
                begin
                    ans = '{32'd0, osnl_pkg::OUT_DEC};
                end
                expected_answers.push_back(ans);
                clear_string();
            end
            else if (step >= VALUE_LEAD)
            begin
                if (value_count < VALUE_CHARS)
                begin
                    if (c == ",")
                    begin
                        value_count = VALUE_CHARS;
                    end
                    else
                    begin
                        value_count++;
                        case (step)
                            VALUE_LEAD:
                            begin
                                if (c == "0")
                                begin
                                    step = VALUE_ZERO;
                                end
                                else if (c != " ")
                                begin
                                    step = VALUE_DEC;
                                    digits = NUM_UNDECIDED;
                                    negative = 1'b0;
                                    take_decimal(c);
                                end
                            end
                            VALUE_ZERO:
                            begin
                                acc = '0;
                                negative = 1'b0;
                                if (c == "x")
                                begin
                                    step = VALUE_HEX;
                                    digits = NUM_UNDECIDED;
                                end
                                else
                                begin
                                    step = VALUE_DEC;
                                    digits = NUM_DIGITS;
                                    take_decimal(c);
                                end
                            end
                            VALUE_HEX:
                            begin
                                // once bad, hold the bad mark to the end
                                if (digits != NUM_BAD)
                                begin
                                    if (c >= "0" && c <= "9")
                                        acc = {acc[27:0], c[3:0]};
                                    else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
                                        acc = {acc[27:0], 4'(c[3:0] + 4'd9)};
                                    else
                                        digits = NUM_BAD;
                                end
                            end
                            default: take_decimal(c);
                        endcase
                    end
                end
            end
            else if (step == SKIP_ENTRY)
            begin
                if (c == ",")
                    start_entry();
            end
            else if ((step == ENTRY_START || step == ENTRY_SPACES) && c == " ")
            begin
                step = ENTRY_SPACES;
            end
            else if (c == ",")
            begin
                if (name_hit())
                    take_bare();
                else
                    start_entry();
            end
            else if (c == "=")
            begin
                if (name_hit())
                begin
                    found = 1'b1;
                    step = VALUE_LEAD;
                    value_count = 0;
                    acc = '0;
                    digits = NUM_UNDECIDED;
                    negative = 1'b0;
                end
                else
                begin
                    step = SKIP_ENTRY;
                end
            end
            else
            begin
                if (key_equal && key_pos < key_span() && key_text[key_pos*8 +: 8] == c)
                    key_pos++;
                else
                    key_equal = 1'b0;
                step = NAME_TEXT;
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at answer %0d: %s", answers_seen, msg);
            failures++;
        endtask

        task check_result(logic [31:0] number, logic [1:0] outcome);
            lookup_answer_t want;
            if (expected_answers.size() == 0)
            begin
                report_mismatch($sformatf("unexpected answer number=%0d outcome=%0d",
                                          $signed(number), outcome));
            end
            else
            begin
                want = expected_answers.pop_front();
                answers_seen++;
                outcome_tally[want.outcome]++;
                if (number !== want.number)
                    report_mismatch($sformatf("number %0d, expected %0d",
                                              $signed(number), $signed(want.number)));
                if (outcome !== want.outcome)
                    report_mismatch($sformatf("outcome %0d, expected %0d",
                                              outcome, want.outcome));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                             cfg_write;
    logic [osnl_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [63:0]                      cfg_data;

    osnl_in_if  text_ch();
    osnl_out_if result_ch();

    option_string_number_lookup_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .text      (text_ch),
        .result    (result_ch)
    );

    lookup_scoreboard sb;
    bit [7:0]    line_buf[$];
    bit [63:0]   cur_key_text;
    bit [3:0]    cur_key_len;
    bit [31:0]   cur_default;
    int          items_sent = 0;
    int          strings_sent = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          long_hold_due = 1'b0;
    int          quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function bit [7:0] pick_char(string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    function void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    // exact key, shortened, lengthened, one char off, or random name
    function void add_name();
        int unsigned span;
        int unsigned r;
        int unsigned n;
        int unsigned idx;
        span = (cur_key_len > KEY_CHARS) ? KEY_CHARS : cur_key_len;
        r = $urandom_range(9);
        if (r <= 6)
        begin
            n = (r == 4 && span > 0) ? span - 1 : span;
            for (int i = 0; i < n; i++)
                line_buf.push_back(cur_key_text[i*8 +: 8]);
            if (r == 5)
                line_buf.push_back(pick_char("abc "));
            if (r == 6 && span > 0)
            begin
                idx = line_buf.size() - 1 - $urandom_range(span - 1);
                line_buf[idx] = line_buf[idx] ^ 8'h01;
            end
        end
        else
        begin
            repeat ($urandom_range(4))
                line_buf.push_back(pick_char("abc "));
        end
    endfunction

    function void add_value();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(19);
        if (r <= 6 || r >= 18)
        begin
            repeat ($urandom_range(1))
                line_buf.push_back(" ");
            if ($urandom_range(3) == 0)
                line_buf.push_back(8'($urandom_range(9, 13)));
            n = $urandom_range(2);
            if (n == 1)
                line_buf.push_back("+");
            else if (n == 2)
                line_buf.push_back("-");
            repeat ($urandom_range(12))
                line_buf.push_back(pick_char("0123456789"));
            if ($urandom_range(3) == 0)
                line_buf.push_back(pick_char("x9- a="));
        end
        else if (r <= 11)
        begin
            line_buf.push_back("0");
            line_buf.push_back(pick_char("xxxxxxxX"));
            repeat ($urandom_range(10))
                line_buf.push_back(pick_char("0123456789abcdefABCDEF"));
            if ($urandom_range(3) == 0)
            begin
                line_buf.push_back(pick_char("gGz-. x"));
                repeat ($urandom_range(3))
                    line_buf.push_back(pick_char("0123456789abcdefABCDEF"));
            end
        end
        else if (r <= 13)
        begin
            line_buf.push_back("0");
            repeat ($urandom_range(4))
                line_buf.push_back(pick_char("0123456789"));
        end
        else if (r == 14)
        begin
            // run near or past the value length limit
            if ($urandom_range(1) == 1)
                push_text("0x");
            repeat ($urandom_range(30, 40))
                line_buf.push_back(pick_char("0123456789abcdef"));
        end
        else if (r <= 16)
        begin
            repeat ($urandom_range(1, 4))
                line_buf.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    function void build_line();
        int unsigned entries;
        line_buf.delete();
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 12))
                line_buf.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            entries = $urandom_range(1, 4);
            for (int e = 0; e < entries; e++)
            begin
                if (e > 0)
                    line_buf.push_back(",");
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(1, 2))
                        line_buf.push_back(" ");
                add_name();
                if ($urandom_range(9) < 7)
                begin
                    line_buf.push_back("=");
                    add_value();
                end
            end
            if ($urandom_range(5) == 0)
            begin
                line_buf.push_back(",");
                repeat ($urandom_range(2))
                    line_buf.push_back(" ");
            end
        end
        line_buf.push_back(8'h00);
    endfunction

    task send_byte(bit [7:0] c);
        if (items_sent < MODE_SPLIT)
        begin
            send_idle_pct = 14;
            recv_idle_pct = 85;
        end
        else if (items_sent < 2 * MODE_SPLIT)
        begin
            send_idle_pct = 85;
            recv_idle_pct = 14;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if (items_sent == LONG_HOLD_AT)
            long_hold_due = 1'b1;
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_ch.valid <= 1'b0;
            @(posedge clk);
        end
        text_ch.valid <= 1'b1;
        text_ch.text_byte <= c;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task send_line();
        foreach (line_buf[i])
            send_byte(line_buf[i]);
        strings_sent++;
    endtask

    task send_text(string s);
        line_buf.delete();
        push_text(s);
        line_buf.push_back(8'h00);
        send_line();
    endtask

    task write_settings();
        cfg_write <= 1'b1;
        cfg_index <= osnl_pkg::REG_KEY_TEXT;
        cfg_data <= cur_key_text;
        @(posedge clk);
        cfg_index <= osnl_pkg::REG_KEY_LENGTH;
        cfg_data <= {60'd0, cur_key_len};
        @(posedge clk);
        cfg_index <= osnl_pkg::REG_DEFAULT_NUMBER;
        cfg_data <= {32'd0, cur_default};
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_register(osnl_pkg::REG_KEY_TEXT, cur_key_text);
        sb.write_register(osnl_pkg::REG_KEY_LENGTH, {60'd0, cur_key_len});
        sb.write_register(osnl_pkg::REG_DEFAULT_NUMBER, {32'd0, cur_default});
    endtask

    task wait_drain();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int goal;
        sb = new();
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        text_ch.valid = 1'b0;
        text_ch.text_byte = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < SETTINGS_COUNT; p++)
        begin
            cur_key_text = {$urandom(), $urandom()};
            cur_default = $urandom();
            cur_key_len = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15))
                                                   : 4'($urandom_range(8));
            case (p)
                0:
                begin
                    cur_key_len = 4'd2;
                    cur_default = 32'h8000_0000;
                end
                1:
                begin
                    cur_key_text = '1;
                    cur_key_len = 4'd0;
                    cur_default = 32'h7FFF_FFFF;
                end
                2:
                begin
                    cur_key_len = 4'd15;
                    cur_default = 32'd0;
                end
                3:
                begin
                    cur_key_len = 4'd8;
                    cur_default = 32'hFFFF_FFFF;
                end
                default: ;
            endcase
            if (p != 1)
                for (int i = 0; i < KEY_CHARS; i++)
                    if (i < cur_key_len)
                        cur_key_text[i*8 +: 8] = pick_char("abc");
            if (p == 0)
                cur_key_text[15:0] = {"b", "a"};
            write_settings();
            if (p == 0)
            begin
                send_text("ab=0x1g");
                send_text(" ab");
                line_buf = {8'hFF};
                push_text(",ab=-9");
                line_buf.push_back(8'h00);
                send_line();
                send_text("");
            end
            goal = (p + 1) * ITEM_TARGET / SETTINGS_COUNT;
            while (items_sent < goal)
            begin
                build_line();
                send_line();
            end
            text_ch.valid <= 1'b0;
            wait_drain();
        end
        $display("Sent %0d characters in %0d strings under %0d key settings,",
                 items_sent, strings_sent, SETTINGS_COUNT);
        $display("with both sides stalling; answers checked: %0d", sb.answers_seen);
        $display("(absent %0d, decimal or bare %0d, hex %0d, bad hex %0d).",
                 sb.outcome_tally[osnl_pkg::OUT_ABSENT], sb.outcome_tally[osnl_pkg::OUT_DEC],
                 sb.outcome_tally[osnl_pkg::OUT_HEX], sb.outcome_tally[osnl_pkg::OUT_BAD_HEX]);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stalls, plus one long hold-off to back up the input
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (text_ch.valid && text_ch.ready)
            sb.note_request(text_ch.text_byte);
        if (result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.number, result_ch.outcome);
    end

    always @(posedge clk)
    begin
        if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
